/* hdl/npb_pkg.sv */
// Shared types, constants and helper functions for the nibble pixel blitter.
// No dependencies; npb_cfg, npb_pix, npb_seq, the top level and the checker import it.
`default_nettype none

package npb_pkg;

    // Pixel memory geometry
    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // APB register map: register i at byte address 4*i
    localparam int PADDR_W      = 3;
    localparam logic REG_SIZE_XOR = 1'b0;
    localparam logic REG_CLIP     = 1'b1;

    // Blitter register file indexes
    localparam logic [2:0] BREG_CTL     = 3'd0;
    localparam logic [2:0] BREG_SOLID   = 3'd1;
    localparam logic [2:0] BREG_SRC_HI  = 3'd2;
    localparam logic [2:0] BREG_SRC_LO  = 3'd3;
    localparam logic [2:0] BREG_DST_HI  = 3'd4;
    localparam logic [2:0] BREG_DST_LO  = 3'd5;
    localparam logic [2:0] BREG_WIDTH   = 3'd6;
    localparam logic [2:0] BREG_HEIGHT  = 3'd7;

    // Control byte bits
    localparam int CTL_SRC_SCREEN = 0;
    localparam int CTL_DST_SCREEN = 1;
    localparam int CTL_TRANSP     = 3;
    localparam int CTL_SOLID      = 4;
    localparam int CTL_SHIFT      = 5;
    localparam int CTL_KEEP_LO    = 6;
    localparam int CTL_KEEP_HI    = 7;

    localparam logic [7:0]  NIB_HI      = 8'hF0;
    localparam logic [7:0]  NIB_LO      = 8'h0F;
    localparam logic [15:0] SCREEN_STEP = 16'h0100;
    localparam logic [15:0] CLIP_RESET  = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_WR   = 2'd0,
        FUNC_RD   = 2'd1,
        FUNC_REG  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef struct packed {
        logic [7:0]  size_xor;
        logic [15:0] clip_limit;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MEM_AW-1:0] raddr;
    } t_ram_cmd;

    typedef struct packed {
        logic        en;
        logic        transp;
        logic        solid;
        logic [7:0]  src;
        logic [7:0]  keep;
        logic [7:0]  colour;
        logic [7:0]  dst_byte;
        logic [15:0] dst_addr;
        logic [15:0] clip;
    } t_pix_req;

    typedef struct packed {
        logic       we;
        logic [7:0] data;
    } t_pix_res;

    function automatic logic in_mem(input logic [15:0] a);
        return {1'b0, a} < 17'(MEM_DEPTH);
    endfunction

    // width/height after the XOR: 0 reads as 1, 255 as 256
    function automatic logic [8:0] size_fix(input logic [7:0] x);
        logic [8:0] r;
        if (x == 8'h00) begin
            r = 9'd1;
        end else if (x == 8'hFF) begin
            r = 9'h100;
        end else begin
            r = {1'b0, x};
        end
        return r;
    endfunction

    function automatic logic [7:0] nib_swap(input logic [7:0] x);
        return {x[3:0], x[7:4]};
    endfunction

endpackage

`default_nettype wire

/* hdl/npb_in_if.sv */
// Request channel of the nibble pixel blitter: valid/ready plus one access.
// No dependencies.
`default_nettype none

interface npb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, func, address, data, input ready);
    modport sink   (input valid, func, address, data, output ready);
endinterface

`default_nettype wire

/* hdl/npb_out_if.sv */
// Response channel of the nibble pixel blitter: valid/ready plus read data.
// No dependencies.
`default_nettype none

interface npb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

/* hdl/npb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module npb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/npb_cfg.sv */
// APB configuration registers: size XOR and clip limit.
// Depends on npb_pkg.
`default_nettype none

module npb_cfg
    import npb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [7:0]  r_size_xor;
    logic [15:0] r_clip;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_xor <= 8'h00;
            r_clip     <= CLIP_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SIZE_XOR: r_size_xor <= pwdata[7:0];
                REG_CLIP:     r_clip     <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SIZE_XOR: prdata = {24'h0, r_size_xor};
            REG_CLIP:     prdata = {16'h0, r_clip};
        endcase
    end

    assign o_cfg.size_xor   = r_size_xor;
    assign o_cfg.clip_limit = r_clip;

endmodule

`default_nettype wire

/* hdl/npb_pix.sv */
// Destination byte merge unit: keep masks, transparency, solid colour, clip test.
// Depends on npb_pkg.
`default_nettype none

module npb_pix
    import npb_pkg::*;
(
    input  wire t_pix_req i_req,
    output t_pix_res      o_res
);

    logic [7:0] tm;
    logic [7:0] val;
    logic       skip;

    always_comb begin
        tm   = i_req.keep;
        val  = i_req.solid ? i_req.colour : i_req.src;
        skip = 1'b0;
        if (i_req.transp) begin
            // colour 0 is see-through, per nibble
            skip = (i_req.src == 8'h00);
            if ((i_req.src & NIB_HI) == 8'h00) tm = tm | NIB_HI;
            if ((i_req.src & NIB_LO) == 8'h00) tm = tm | NIB_LO;
        end
        o_res.data = (i_req.dst_byte & tm) | (val & ~tm);
        o_res.we   = i_req.en && !skip && (i_req.dst_addr < i_req.clip)
                     && in_mem(i_req.dst_addr);
    end

endmodule

`default_nettype wire

/* hdl/npb_seq.sv */
// Sequencer: memory clear pass, CPU accesses, blit address walk, response register.
// Depends on npb_pkg, npb_in_if and npb_out_if.
`default_nettype none

module npb_seq
    import npb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    npb_in_if.sink          i_req,
    npb_out_if.source       o_rsp,
    input  wire t_cfg       i_cfg,
    output t_ram_cmd        o_ram,
    input  wire logic [7:0] i_ram_rdata,
    output t_pix_req        o_pix,
    input  wire t_pix_res   i_pix
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PUSH,
        S_B_SRC,
        S_B_DST,
        S_B_WR
    } t_state;

    t_state            r_state, n_state;
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic [7:0]        r_regs [8];
    logic [7:0]        n_regs [8];
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_data, n_out_data;
    logic [7:0]        r_res, n_res;
    logic              r_rd_ok, n_rd_ok;
    logic [7:0]        r_ctl, n_ctl;
    logic [15:0]       r_src, n_src;
    logic [15:0]       r_dst, n_dst;
    logic [15:0]       r_sstart, n_sstart;
    logic [15:0]       r_dstart, n_dstart;
    logic [8:0]        r_col, n_col;
    logic [8:0]        r_row, n_row;
    logic [3:0]        r_nib, n_nib;
    logic [7:0]        r_srcb, n_srcb;

    logic        ready;
    logic        accept;
    logic [15:0] rd_addr;
    logic [8:0]  w, h, last_col;
    logic        shift, fin;
    logic [7:0]  keep, colour, src_val, keep_eff;
    logic [15:0] sx, sy, dx, row_sstart, row_dstart;

    assign ready       = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && ready;
    assign i_req.ready = ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;

    // blit geometry
    assign w        = size_fix(r_regs[BREG_WIDTH] ^ i_cfg.size_xor);
    assign h        = size_fix(r_regs[BREG_HEIGHT] ^ i_cfg.size_xor);
    assign shift    = r_ctl[CTL_SHIFT];
    assign last_col = shift ? w : w - 9'd1;
    // trailing half-byte of a shifted row: the source byte that is read is not taken
    assign fin      = shift && (r_col == w);
    assign sx = r_ctl[CTL_SRC_SCREEN] ? SCREEN_STEP : 16'h0001;
    assign sy = r_ctl[CTL_SRC_SCREEN] ? 16'h0001 : {7'h00, w};
    assign dx = r_ctl[CTL_DST_SCREEN] ? SCREEN_STEP : 16'h0001;
    assign row_sstart = r_sstart + sy;
    // screen-stride destination wraps inside its column
    assign row_dstart = r_ctl[CTL_DST_SCREEN]
                        ? {r_dstart[15:8], r_dstart[7:0] + 8'h01}
                        : r_dstart + {7'h00, w};

    always_comb begin
        keep = {r_ctl[CTL_KEEP_HI] ? 4'hF : 4'h0, r_ctl[CTL_KEEP_LO] ? 4'hF : 4'h0};
        colour = r_regs[BREG_SOLID];
        if (shift) begin
            keep   = nib_swap(keep);
            colour = nib_swap(colour);
        end
        keep_eff = keep;
        if (!shift) begin
            src_val = r_srcb;
        end else if (fin) begin
            src_val  = {r_nib, 4'h0};
            keep_eff = keep | NIB_LO;
        end else if (r_col == 9'd0) begin
            src_val  = {4'h0, r_srcb[7:4]};
            keep_eff = keep | NIB_HI;
        end else begin
            src_val = {r_nib, r_srcb[7:4]};
        end
    end

    always_comb begin
        o_pix.en       = (r_state == S_B_WR);
        o_pix.transp   = r_ctl[CTL_TRANSP];
        o_pix.solid    = r_ctl[CTL_SOLID];
        o_pix.src      = src_val;
        o_pix.keep     = keep_eff;
        o_pix.colour   = colour;
        o_pix.dst_byte = i_ram_rdata;
        o_pix.dst_addr = r_dst;
        o_pix.clip     = i_cfg.clip_limit;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_regs      = r_regs;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_data  = r_out_data;
        n_res       = r_res;
        n_ctl       = r_ctl;
        n_src       = r_src;
        n_dst       = r_dst;
        n_sstart    = r_sstart;
        n_dstart    = r_dstart;
        n_col       = r_col;
        n_row       = r_row;
        n_nib       = r_nib;
        n_srcb      = r_srcb;
        rd_addr     = i_req.address;
        o_ram.we    = 1'b0;
        o_ram.waddr = i_req.address[MEM_AW-1:0];
        o_ram.wdata = i_req.data;

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
                o_ram.wdata = 8'h00;
                n_clr       = r_clr + 1'b1;
                if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_out_data = 8'h00;
                    unique case (t_func'(i_req.func))
                        FUNC_WR: begin
                            o_ram.we    = in_mem(i_req.address);
                            n_out_valid = 1'b1;
                        end
                        FUNC_RD: begin
                            n_state = S_READ;
                        end
                        FUNC_REG: begin
                            n_out_valid = 1'b1;
                            if (i_req.address[15:3] == 13'h0) begin
                                n_regs[i_req.address[2:0]] = i_req.data;
                                if (i_req.address[2:0] == BREG_CTL &&
                                    !(i_req.data[CTL_KEEP_HI] && i_req.data[CTL_KEEP_LO])) begin
                                    n_out_valid = r_out_valid && !o_rsp.ready;
                                    n_ctl    = i_req.data;
                                    n_src    = {r_regs[BREG_SRC_HI], r_regs[BREG_SRC_LO]};
                                    n_sstart = {r_regs[BREG_SRC_HI], r_regs[BREG_SRC_LO]};
                                    n_dst    = {r_regs[BREG_DST_HI], r_regs[BREG_DST_LO]};
                                    n_dstart = {r_regs[BREG_DST_HI], r_regs[BREG_DST_LO]};
                                    n_col    = 9'd0;
                                    n_row    = 9'd0;
                                    n_nib    = 4'h0;
                                    n_state  = S_B_SRC;
                                end
                            end
                        end
                        FUNC_NONE: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res   = r_rd_ok ? i_ram_rdata : 8'h00;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            S_B_SRC: begin
                rd_addr = r_src;
                n_state = S_B_DST;
            end
            S_B_DST: begin
                if (!fin) begin
                    n_srcb = r_rd_ok ? i_ram_rdata : 8'h00;
                end
                rd_addr = r_dst;
                n_state = S_B_WR;
            end
            S_B_WR: begin
                o_ram.we    = i_pix.we;
                o_ram.waddr = r_dst[MEM_AW-1:0];
                o_ram.wdata = i_pix.data;
                if (shift && !fin) begin
                    n_nib = r_srcb[3:0];
                end
                n_src   = r_src + sx;
                n_dst   = r_dst + dx;
                n_col   = r_col + 9'd1;
                n_state = S_B_SRC;
                if (r_col == last_col) begin
                    n_col = 9'd0;
                    if (r_row == h - 9'd1) begin
                        n_res   = 8'h00;
                        n_state = S_PUSH;
                    end else begin
                        n_row    = r_row + 9'd1;
                        n_sstart = row_sstart;
                        n_dstart = row_dstart;
                        n_src    = row_sstart;
                        n_dst    = row_dstart;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_ram.raddr = rd_addr[MEM_AW-1:0];
        n_rd_ok     = in_mem(rd_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_regs      <= '{default: 8'h00};
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_regs      <= n_regs;
        end
        r_out_data <= n_out_data;
        r_res      <= n_res;
        r_rd_ok    <= n_rd_ok;
        r_ctl      <= n_ctl;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_sstart   <= n_sstart;
        r_dstart   <= n_dstart;
        r_col      <= n_col;
        r_row      <= n_row;
        r_nib      <= n_nib;
        r_srcb     <= n_srcb;
    end

endmodule

`default_nettype wire

/* hdl/nibble_pixel_blitter.sv */
// Nibble pixel blitter top level: memory, sequencer, merge unit and APB registers.
// After reset the block zeroes its 64K byte memory, one byte a cycle, and takes
// no request until that clear pass ends; APB writes are taken throughout. A
// memory write, a register write or an ignored request has its zero response
// registered in the cycle after it is taken; a memory read goes through S_READ and S_PUSH.
// A blit (write to blitter register 0 without both keep bits set) runs S_B_SRC,
// S_B_DST and S_B_WR for each of w*h destination bytes, (w+1)*h with the nibble
// shift, then answers via S_PUSH: each byte needs a source read, a destination
// read and a write, in turn, on the one read port and one write port of the
// memory. Requests are held off while a read or blit runs or a response waits.
`default_nettype none

module nibble_pixel_blitter
    import npb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    npb_in_if.sink                  i_req,
    npb_out_if.source               o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    t_cfg       cfg;
    t_ram_cmd   ram_cmd;
    logic [7:0] ram_rdata;
    t_pix_req   pix_req;
    t_pix_res   pix_res;

    npb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    npb_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (ram_rdata)
    );

    npb_pix u_pix (
        .i_req (pix_req),
        .o_res (pix_res)
    );

    npb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg       (cfg),
        .o_ram       (ram_cmd),
        .i_ram_rdata (ram_rdata),
        .o_pix       (pix_req),
        .i_pix       (pix_res)
    );

endmodule

`default_nettype wire

/* hdl/npb_checker.sv */
// Port-level checks on the nibble pixel blitter, bound to the top level.
// Depends on npb_pkg.
`default_nettype none

module npb_checker
    import npb_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic [1:0] i_in_func,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_data
);

    // memory clear pass holds requests off straight after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during memory clear");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled response changed");

    // no new request while the response register is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken with response blocked");

    // a memory write responds with zero on the next cycle
    a_write_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_func == FUNC_WR)
        |=> i_out_valid && (i_out_data == 8'h00))
        else $error("memory write response missing or non-zero");

endmodule

bind nibble_pixel_blitter npb_checker u_npb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_func   (i_req.func),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.read_data)
);

`default_nettype wire

/* tb/nibble_pixel_blitter_test.sv */
// Self-checking testbench for nibble_pixel_blitter: random and directed accesses and blits
// against a shadow copy of the pixel memory. Depends on npb_pkg, npb_in_if and npb_out_if.
`timescale 1ns / 1ps

module nibble_pixel_blitter_test;
    import npb_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int N_PHASES       = 5;
    localparam int PHASE_ITEMS    = 340;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 400;
    localparam int END_CYCLES     = 16;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        t_func       func;
        logic [15:0] address;
        logic [7:0]  data;
    } t_access;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    npb_in_if  req_if ();
    npb_out_if rsp_if ();

    nibble_pixel_blitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow state of the block
    logic [7:0]  shadow_mem [MEM_DEPTH];
    logic [7:0]  shadow_regs [8];
    logic [7:0]  cfg_size_xor;
    logic [15:0] cfg_clip;

    t_access     pending_access [$];
    logic [7:0]  expected_read_data [$];

    t_access     cur_item;
    logic [7:0]  pred_rd;
    logic [7:0]  want;
    int          burst_left;
    int          gap_left;
    bit          offer;
    int          rx_mode;
    int          rx_left;
    int          hold_left;
    bit          hold_done;
    int          idle_cycles;
    int          n_accepted;
    int          n_results;
    int          n_blits;
    int          n_errors;

    // ---------------------------------------------------------------- shadow model

    function automatic logic [7:0] shadow_rd(input logic [15:0] a);
        return (int'(a) < MEM_DEPTH) ? shadow_mem[a] : 8'h00;
    endfunction

    task automatic merge_pixel(input logic transp, input logic solid_m,
                               input logic [15:0] dst, input logic [7:0] src,
                               input logic [7:0] keep, input logic [7:0] colour);
        logic [7:0] tm;
        logic [7:0] val;
        tm  = keep;
        val = solid_m ? colour : src;
        if (transp) begin
            if ((src & NIB_HI) == 8'h00) tm = tm | NIB_HI;
            if ((src & NIB_LO) == 8'h00) tm = tm | NIB_LO;
        end
        // transparent mode skips a source byte of colour 0 altogether
        if (!(transp && src == 8'h00)) begin
            if (int'(dst) < MEM_DEPTH && dst < cfg_clip)
                shadow_mem[dst] = (shadow_rd(dst) & tm) | (val & ~tm);
        end
    endtask

    task automatic shadow_blit(input logic [7:0] ctl);
        logic [15:0] sstart;
        logic [15:0] dstart;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] dx;
        logic [7:0]  wr;
        logic [7:0]  hr;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [7:0]  keep;
        logic [7:0]  colour;
        logic [11:0] pd;
        logic        transp;
        logic        solid_m;
        int          i;
        int          j;
        sstart  = {shadow_regs[BREG_SRC_HI], shadow_regs[BREG_SRC_LO]};
        dstart  = {shadow_regs[BREG_DST_HI], shadow_regs[BREG_DST_LO]};
        wr      = shadow_regs[BREG_WIDTH] ^ cfg_size_xor;
        hr      = shadow_regs[BREG_HEIGHT] ^ cfg_size_xor;
        w       = (wr == 8'h00) ? 9'd1 : (wr == 8'hFF) ? 9'd256 : {1'b0, wr};
        h       = (hr == 8'h00) ? 9'd1 : (hr == 8'hFF) ? 9'd256 : {1'b0, hr};
        transp  = ctl[CTL_TRANSP];
        solid_m = ctl[CTL_SOLID];
        sx      = ctl[CTL_SRC_SCREEN] ? SCREEN_STEP : 16'd1;
        sy      = ctl[CTL_SRC_SCREEN] ? 16'd1 : {7'h0, w};
        dx      = ctl[CTL_DST_SCREEN] ? SCREEN_STEP : 16'd1;
        keep    = {ctl[CTL_KEEP_HI] ? 4'hF : 4'h0, ctl[CTL_KEEP_LO] ? 4'hF : 4'h0};
        colour  = shadow_regs[BREG_SOLID];
        // keeping both nibbles turns the blit into a no-op
        if (keep != 8'hFF) begin
            if (ctl[CTL_SHIFT]) begin
                keep   = {keep[3:0], keep[7:4]};
                colour = {colour[3:0], colour[7:4]};
            end
            for (i = 0; i < int'(h); i++) begin
                src = sstart;
                dst = dstart;
                if (!ctl[CTL_SHIFT]) begin
                    for (j = 0; j < int'(w); j++) begin
                        merge_pixel(transp, solid_m, dst, shadow_rd(src), keep, colour);
                        src = src + sx;
                        dst = dst + dx;
                    end
                end else begin
                    // shifted rows write one byte more than the width
                    pd = {4'h0, shadow_rd(src)};
                    merge_pixel(transp, solid_m, dst, {4'h0, pd[7:4]}, keep | NIB_HI, colour);
                    src = src + sx;
                    dst = dst + dx;
                    for (j = 1; j < int'(w); j++) begin
                        pd = {pd[3:0], shadow_rd(src)};
                        merge_pixel(transp, solid_m, dst, pd[11:4], keep, colour);
                        src = src + sx;
                        dst = dst + dx;
                    end
                    merge_pixel(transp, solid_m, dst, {pd[3:0], 4'h0}, keep | NIB_LO, colour);
                end
                sstart = sstart + sy;
                // screen-stride destination stays within its 256-byte column
                if (ctl[CTL_DST_SCREEN])
                    dstart[7:0] = dstart[7:0] + 8'd1;
                else
                    dstart = dstart + {7'h0, w};
            end
        end
    endtask

    task automatic shadow_access(input t_access it, output logic [7:0] rd);
        rd = 8'h00;
        case (it.func)
            FUNC_WR: begin
                if (int'(it.address) < MEM_DEPTH) shadow_mem[it.address] = it.data;
            end
            FUNC_RD: begin
                rd = shadow_rd(it.address);
            end
            FUNC_REG: begin
                if (it.address < 16'd8) begin
                    shadow_regs[it.address[2:0]] = it.data;
                    if (it.address[2:0] == BREG_CTL) begin
                        n_blits++;
                        shadow_blit(it.data);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic void push_access(input t_func f, input logic [15:0] a,
                                        input logic [7:0] d);
        t_access it;
        it.func    = f;
        it.address = a;
        it.data    = d;
        pending_access.push_back(it);
    endfunction

    function automatic void push_breg(input logic [2:0] idx, input logic [7:0] d);
        push_access(FUNC_REG, {13'h0, idx}, d);
    endfunction

    function automatic logic [7:0] pick_page();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // plenty of empty nibbles so that transparency gets exercised
    function automatic logic [7:0] rand_pixel();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       v = 8'h00;
            1:       v = v & NIB_HI;
            2:       v = v & NIB_LO;
            default: ;
        endcase
        return v;
    endfunction

    // register value for a given effective size; mostly small, now and then large
    function automatic logic [7:0] size_reg(input bit big_ok);
        logic [7:0] e;
        int         r;
        r = $urandom_range(0, 39);
        if (r == 0)
            e = 8'h00;
        else if (r == 1 && big_ok)
            e = 8'hFF;
        else if (r < 4 && big_ok)
            e = 8'($urandom_range(9, 40));
        else
            e = 8'($urandom_range(1, 8));
        return e ^ cfg_size_xor;
    endfunction

    function automatic int queue_blit();
        logic [15:0] src;
        logic [15:0] dst;
        logic [7:0]  ctl;
        logic [7:0]  wreg;
        logic [7:0]  hreg;
        int          n;
        int          k;
        int          n_pre;
        int          n_rd;
        int          stride;
        n   = 0;
        src = {pick_page(), 8'($urandom)};
        dst = {pick_page(), 8'($urandom)};
        ctl = 8'($urandom);
        if (ctl[CTL_KEEP_HI] && ctl[CTL_KEEP_LO] && $urandom_range(0, 3) != 0)
            ctl[CTL_KEEP_LO] = 1'b0;
        stride = ctl[CTL_SRC_SCREEN] ? 256 : 1;
        n_pre  = $urandom_range(0, 6);
        for (k = 0; k < n_pre; k++) begin
            push_access(FUNC_WR, src + 16'(k * stride), rand_pixel());
            n++;
        end
        if ($urandom_range(0, 3) != 0) begin push_breg(BREG_SOLID, rand_pixel()); n++; end
        if ($urandom_range(0, 7) != 0) begin push_breg(BREG_SRC_HI, src[15:8]); n++; end
        if ($urandom_range(0, 7) != 0) begin push_breg(BREG_SRC_LO, src[7:0]); n++; end
        if ($urandom_range(0, 7) != 0) begin push_breg(BREG_DST_HI, dst[15:8]); n++; end
        if ($urandom_range(0, 7) != 0) begin push_breg(BREG_DST_LO, dst[7:0]); n++; end
        // sizes are always rewritten so a stale value never turns into a huge blit
        wreg = size_reg(1'b1);
        hreg = size_reg((wreg ^ cfg_size_xor) <= 8'd8);
        push_breg(BREG_WIDTH, wreg);
        push_breg(BREG_HEIGHT, hreg);
        push_breg(BREG_CTL, ctl);
        n    = n + 3;
        n_rd = $urandom_range(1, 4);
        for (k = 0; k < n_rd; k++) begin
            push_access(FUNC_RD,
                dst + 16'($urandom_range(0, 3) * (ctl[CTL_DST_SCREEN] ? 256 : 1))
                    + 16'($urandom_range(0, 3)),
                8'($urandom));
            n++;
        end
        return n;
    endfunction

    task automatic queue_random(input int n_items);
        int count;
        int r;
        int k;
        int nw;
        logic [15:0] a;
        count = 0;
        while (count < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                count = count + queue_blit();
            end else if (r < 55) begin
                a  = {pick_page(), 8'($urandom)};
                nw = $urandom_range(1, 4);
                for (k = 0; k < nw; k++) push_access(FUNC_WR, a + 16'(k), rand_pixel());
                count = count + nw;
            end else if (r < 88) begin
                push_access(FUNC_RD, {pick_page(), 8'($urandom)}, 8'($urandom));
                count++;
            end else begin
                case ($urandom_range(0, 2))
                    0: push_access(FUNC_NONE, 16'($urandom), 8'($urandom));
                    1: push_access(FUNC_REG, 16'($urandom_range(8, 65535)), 8'($urandom));
                    default: push_access(FUNC_WR, 16'($urandom), 8'($urandom));
                endcase
                count++;
            end
        end
    endtask

    task automatic queue_directed();
        push_access(FUNC_WR, 16'h1000, 8'h12);
        push_access(FUNC_WR, 16'h1001, 8'h30);
        push_access(FUNC_WR, 16'hFFFF, 8'hFF);
        push_access(FUNC_RD, 16'hFFFF, 8'hFF);
        push_access(FUNC_NONE, 16'hFFFF, 8'hFF);
        push_access(FUNC_REG, 16'hFFFF, 8'hFF);     // register index out of range
        push_breg(BREG_SOLID, 8'hA5);
        push_breg(BREG_SRC_HI, 8'h10);
        push_breg(BREG_SRC_LO, 8'h00);
        push_breg(BREG_DST_HI, 8'hFF);
        push_breg(BREG_DST_LO, 8'hFE);
        push_breg(BREG_WIDTH, 8'hFF);               // reads as 256
        push_breg(BREG_HEIGHT, 8'h00);              // reads as 1
        push_breg(BREG_CTL, 8'h22);                 // nibble shift, screen dest wraps 16 bits
        push_access(FUNC_RD, 16'h00FE, 8'h00);
        push_breg(BREG_CTL, 8'hC0);                 // both nibbles kept: no-op
        push_breg(BREG_WIDTH, 8'h02);
        push_breg(BREG_HEIGHT, 8'hFF);
        push_breg(BREG_CTL, 8'h1B);                 // screen src/dest, transparent solid
        push_access(FUNC_RD, 16'hFFFF, 8'h00);
        push_access(FUNC_RD, 16'hFF00, 8'h00);      // column wrap of the destination
        push_breg(BREG_CTL, 8'h88);                 // transparent, keep high nibble
        push_breg(BREG_CTL, 8'h44);                 // keep low nibble, inert bit set
        push_access(FUNC_RD, 16'hFFFE, 8'h00);
    endtask

    // ---------------------------------------------------------------- APB

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        v = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sx, input logic [15:0] cl);
        logic [31:0] rb;
        apb_write(PADDR_W'(4 * int'(REG_SIZE_XOR)), {24'h0, sx});
        apb_write(PADDR_W'(4 * int'(REG_CLIP)), {16'h0, cl});
        cfg_size_xor = sx;
        cfg_clip     = cl;
        apb_read(PADDR_W'(4 * int'(REG_SIZE_XOR)), rb);
        if (rb[7:0] !== sx) begin
            n_errors++;
            $display("%0t: size_xor readback, expected %02h, got %02h", $time, sx, rb[7:0]);
        end
        apb_read(PADDR_W'(4 * int'(REG_CLIP)), rb);
        if (rb[15:0] !== cl) begin
            n_errors++;
            $display("%0t: clip_limit readback, expected %04h, got %04h", $time, cl, rb[15:0]);
        end
    endtask

    // wait until every queued access has been transferred and answered
    task automatic drain();
        while (pending_access.size() != 0 || req_if.valid
               || expected_read_data.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- clock, sequence

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int          p;
        logic [7:0]  sx;
        logic [15:0] cl;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_WR;
        req_if.address  = 16'h0000;
        req_if.data     = 8'h00;
        rsp_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = 32'h0;
        n_errors        = 0;
        n_blits         = 0;
        cfg_size_xor    = 8'h00;
        cfg_clip        = CLIP_RESET;
        foreach (shadow_mem[k]) shadow_mem[k] = 8'h00;
        foreach (shadow_regs[k]) shadow_regs[k] = 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0:       begin sx = 8'h00; cl = CLIP_RESET; end
                1:       begin sx = 8'h04; cl = 16'h8000; end
                2:       begin sx = 8'hFF; cl = 16'h0000; end
                default: begin sx = 8'($urandom); cl = 16'($urandom); end
            endcase
            set_config(sx, cl);
            if (p == 0) queue_directed();
            queue_random(PHASE_ITEMS);
        end
        drain();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d blits and %0d responses over %0d register settings",
                 n_accepted, n_blits, n_results, N_PHASES);
        if (n_errors == 0 && expected_read_data.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------- request driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            n_accepted <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                shadow_access(cur_item, pred_rd);
                expected_read_data.push_back(pred_rd);
                n_accepted <= n_accepted + 1;
            end
            // a new item is offered only once the previous one has been transferred
            if (!(req_if.valid && !req_if.ready)) begin
                offer = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_access.size() != 0) begin
                    cur_item = pending_access.pop_front();
                    offer    = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end
                req_if.valid   <= offer;
                req_if.func    <= cur_item.func;
                req_if.address <= cur_item.address;
                req_if.data    <= cur_item.data;
            end
        end
    end

    // ---------------------------------------------------------------- response monitor

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_mode      <= 0;
            rx_left      <= 0;
            n_results    <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_results <= n_results + 1;
                if (expected_read_data.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected response, expected none, got %02h",
                                 $time, rsp_if.read_data);
                end else begin
                    want = expected_read_data.pop_front();
                    if (rsp_if.read_data !== want) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: read_data mismatch, expected %02h, got %02h",
                                     $time, want, rsp_if.read_data);
                    end
                end
            end
            // stall pattern: free-running, half-and-half, or mostly stalled stretches
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(8, 120);
            end else begin
                rx_left <= rx_left - 1;
            end
            rsp_if.ready <= (hold_left == 0)
                && (rx_mode == 0 || (rx_mode == 1 && $urandom_range(0, 1) == 1)
                    || (rx_mode == 2 && $urandom_range(0, 5) == 0));
        end
    end

    // one long hold-off on the response side so that the request side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_results >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

/* nibble_pixel_blitter.f */
hdl/npb_pkg.sv
hdl/npb_in_if.sv
hdl/npb_out_if.sv
hdl/npb_ram.sv
hdl/npb_cfg.sv
hdl/npb_pix.sv
hdl/npb_seq.sv
hdl/nibble_pixel_blitter.sv
hdl/npb_checker.sv
tb/nibble_pixel_blitter_test.sv
